// ===== src/pccs_pkg.sv =====
// ----------------------------------------------------------------------------
// pccs_pkg
// shared types and constants of the piecewise-constant cdf sampler
// ----------------------------------------------------------------------------
`default_nettype none

package pccs_pkg;

    localparam int SUM_BITS = 24;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] weight;
        logic [15:0] sample_u;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  bin_index;
        logic [15:0] remapped_u;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic search_init;
        logic search_rd;
        logic search_cmp;
        logic read_upper;
        logic read_lower;
        logic load_div;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sample_err;
        logic search_done;
        logic div_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/piecewise_constant_cdf_sampler_top.sv =====
// ----------------------------------------------------------------------------
// piecewise_constant_cdf_sampler_top
// append, clear, nop and rejected samples pass from the accepting state to the
//   output state, which registers the result; a sample runs the binary search
//   over the single read port and the one-bit-a-cycle divider
// one item at a time: the next transfer is taken once the result is registered
// synchronous active-low reset empties the table; the stored sums need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_constant_cdf_sampler_top #(
    parameter int ENTRIES       = 256,
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire pccs_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output pccs_pkg::t_out_item      o_out_data
);
    pccs_pkg::t_cmd cmd;
    pccs_pkg::t_sts sts;

    pccs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_data.operation),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    pccs_datapath #(
        .ENTRIES       (ENTRIES),
        .WEIGHT_BITS   (WEIGHT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_data),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_out_data)
    );

endmodule

`default_nettype wire

// ===== src/pccs_datapath.sv =====
// ----------------------------------------------------------------------------
// pccs_datapath
// prefix-sum table, binary search registers and serial remap divider
// ----------------------------------------------------------------------------
`default_nettype none

module pccs_datapath #(
    parameter int ENTRIES       = 256,
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pccs_pkg::t_in_item  i_item,
    input  wire pccs_pkg::t_cmd      i_cmd,
    output pccs_pkg::t_sts           o_sts,
    output pccs_pkg::t_out_item      o_result
);
    localparam int SB  = pccs_pkg::SUM_BITS;
    localparam int FB  = FRACTION_BITS;
    localparam int AW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int PW  = SB + FB;
    localparam int SW  = $clog2(FB);
    localparam int UW  = (FB > 16) ? FB : 16;
    localparam int WW  = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;
    localparam int QX  = (FB > 16) ? FB : 16;
    localparam int BX  = (CW > 8) ? CW : 8;
    localparam logic [UW-1:0] U_MAX = UW'((64'd1 << FB) - 64'd1);
    localparam logic [WW-1:0] W_MASK = WW'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [SB:0] SUM_MAX = {1'b0, {SB{1'b1}}};

    logic [SB-1:0] r_mem [ENTRIES];
    logic [SB-1:0] r_rdata;
    logic [CW-1:0] r_count;
    logic [SB-1:0] r_total;
    logic [PW-1:0] r_scaled;
    logic [CW-1:0] r_lo, r_hi, r_mid, r_k;
    logic [SB-1:0] r_upper, r_den, r_rem;
    logic [FB-1:0] r_nlo, r_q;
    logic          r_den_zero;
    logic [SW-1:0] r_step;
    pccs_pkg::t_out_item r_res, r_out;

    logic [AW-1:0] rd_addr;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] k_sel;
    logic [SB-1:0] thr, lower;
    logic [SB:0]   sum_ext, sum_sat;
    logic [WW-1:0] w_eff;
    logic [UW-1:0] u_ext, u_sat;
    logic [PW-1:0] num;
    logic [SB:0]   rem2, rem_sub;
    logic          q_bit;
    logic [FB-1:0] q_next;
    logic [QX-1:0] q_ext;
    logic [BX-1:0] k_ext;
    logic [1:0]    acc_status;

    assign thr     = r_scaled[PW-1:FB];
    assign mid_sum = ({1'b0, r_lo} + {1'b0, r_hi}) >> 1;
    assign k_sel   = (r_lo >= r_count) ? (r_count - CW'(1)) : r_lo;
    assign w_eff   = WW'(i_item.weight) & W_MASK;
    assign sum_ext = {1'b0, r_total} + (SB + 1)'(w_eff);
    assign sum_sat = (sum_ext > SUM_MAX) ? SUM_MAX : sum_ext;
    assign u_ext   = UW'(i_item.sample_u);
    assign u_sat   = (u_ext > U_MAX) ? U_MAX : u_ext;
    assign lower   = (r_k == '0) ? '0 : r_rdata;
    assign num     = r_scaled - {lower, {FB{1'b0}}};
    assign rem2    = {r_rem, r_nlo[FB-1]};
    assign rem_sub = rem2 - {1'b0, r_den};
    assign q_bit   = (rem2 >= {1'b0, r_den});
    assign q_next  = {r_q[FB-2:0], q_bit};
    assign q_ext   = QX'(q_next);
    assign k_ext   = BX'(r_k);

    always_comb begin
        rd_addr = AW'(mid_sum);
        if (i_cmd.read_upper) begin
            rd_addr = AW'(k_sel);
        end else if (i_cmd.read_lower) begin
            rd_addr = AW'(r_k - CW'(1));
        end
    end

    always_comb begin
        acc_status = pccs_pkg::ST_OK;
        case (i_item.operation)
            pccs_pkg::OP_APPEND: begin
                if (r_count == CW'(ENTRIES)) begin
                    acc_status = pccs_pkg::ST_FULL;
                end
            end
            pccs_pkg::OP_SAMPLE: begin
                if (o_sts.sample_err) begin
                    acc_status = pccs_pkg::ST_EMPTY;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.sample_err  = (r_count == '0) || (r_total == '0);
    assign o_sts.search_done = (r_lo >= r_hi);
    assign o_sts.div_last    = (r_step == SW'(FB - 1));
    assign o_result          = r_out;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (i_cmd.accept && i_item.operation == pccs_pkg::OP_APPEND
                && r_count != CW'(ENTRIES)) begin
            r_mem[AW'(r_count)] <= sum_sat[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
        end else if (i_cmd.accept) begin
            case (i_item.operation)
                pccs_pkg::OP_APPEND: begin
                    if (r_count != CW'(ENTRIES)) begin
                        r_count <= r_count + CW'(1);
                        r_total <= sum_sat[SB-1:0];
                    end
                end
                pccs_pkg::OP_CLEAR: begin
                    r_count <= '0;
                    r_total <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res    <= '{bin_index: 8'd0, remapped_u: 16'd0, status: acc_status};
            r_scaled <= PW'(u_sat[FB-1:0]) * PW'(r_total);
        end
        if (i_cmd.search_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end
        if (i_cmd.search_rd) begin
            r_mid <= mid_sum[CW-1:0];
        end
        if (i_cmd.search_cmp) begin
            if (r_rdata > thr) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid + CW'(1);
            end
        end
        if (i_cmd.read_upper) begin
            r_k <= k_sel;
        end
        if (i_cmd.read_lower) begin
            r_upper <= r_rdata;
        end
        if (i_cmd.load_div) begin
            r_den      <= r_upper - lower;
            r_den_zero <= (r_upper == lower);
            r_rem      <= num[PW-1:FB];
            r_nlo      <= num[FB-1:0];
            r_q        <= '0;
            r_step     <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= q_bit ? rem_sub[SB-1:0] : rem2[SB-1:0];
            r_nlo  <= {r_nlo[FB-2:0], 1'b0};
            r_q    <= q_next;
            r_step <= r_step + SW'(1);
            if (o_sts.div_last) begin
                r_res <= '{bin_index:  k_ext[7:0],
                           remapped_u: r_den_zero ? 16'd0 : q_ext[15:0],
                           status:     pccs_pkg::ST_OK};
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

endmodule

`default_nettype wire

// ===== src/pccs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pccs_ctrl
// sequencer for append, clear, binary search, remap division and output
// ----------------------------------------------------------------------------
`default_nettype none

module pccs_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic [1:0]         i_operation,
    input  wire logic               i_out_stall,
    input  wire pccs_pkg::t_sts     i_sts,
    output pccs_pkg::t_cmd          o_cmd,
    output logic                    o_in_stall,
    output logic                    o_out_valid
);
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SRD, S_SCMP, S_RD_UP, S_RD_LO, S_LOAD, S_DIV, S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd             = '0;
        o_cmd.accept      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.search_init = (r_state == S_INIT);
        o_cmd.search_rd   = (r_state == S_SRD) && !i_sts.search_done;
        o_cmd.search_cmp  = (r_state == S_SCMP);
        o_cmd.read_upper  = (r_state == S_RD_UP);
        o_cmd.read_lower  = (r_state == S_RD_LO);
        o_cmd.load_div    = (r_state == S_LOAD);
        o_cmd.div_step    = (r_state == S_DIV);
        o_cmd.out_load    = (r_state == S_FINISH) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_operation == pccs_pkg::OP_SAMPLE && !i_sts.sample_err) begin
                            r_state <= S_INIT;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_INIT:  r_state <= S_SRD;
                S_SRD:   r_state <= i_sts.search_done ? S_RD_UP : S_SCMP;
                S_SCMP:  r_state <= S_SRD;
                S_RD_UP: r_state <= S_RD_LO;
                S_RD_LO: r_state <= S_LOAD;
                S_LOAD:  r_state <= S_DIV;
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/pccs_checker.sv =====
// ----------------------------------------------------------------------------
// pccs_checker
// port-level checks of the sampler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pccs_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                o_in_stall,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_stall,
    input  wire pccs_pkg::t_out_item o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer taken before result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= pccs_pkg::ST_FULL)
        else $error("bad status code");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != pccs_pkg::ST_OK
            |-> o_out_data.bin_index == '0 && o_out_data.remapped_u == '0)
        else $error("error result carries data");

endmodule

bind piecewise_constant_cdf_sampler_top pccs_checker u_pccs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the piecewise-constant cdf sampler against a behavioural predictor:
// append, sample and clear transfers, table full and empty cases, random idling
// on both sides and a drain pause
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;

    localparam int ENTRIES = 256;
    localparam int LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    pccs_pkg::t_in_item in_data = '0;
    logic in_stall;
    logic out_valid;
    pccs_pkg::t_out_item out_data;

    pccs_pkg::t_in_item pending_q[$];
    pccs_pkg::t_out_item expected_q[$];
    logic [23:0] cdf_table[ENTRIES];
    int bin_count;
    int error_count = 0;
    int idle_cycles = 0;
    int quiet_pct = 27;
    bit hold_sender = 1'b0;
    bit stim_done = 1'b0;

    piecewise_constant_cdf_sampler_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic pccs_pkg::t_out_item predict_draw(pccs_pkg::t_in_item it);
        pccs_pkg::t_out_item r;
        logic [63:0] total, scaled, lower, upper, num, sum;
        int k;
        r = '0;
        case (it.operation)
            pccs_pkg::OP_APPEND: begin
                if (bin_count >= ENTRIES) begin
                    r.status = pccs_pkg::ST_FULL;
                end else begin
                    sum = (bin_count == 0 ? 64'd0 : 64'(cdf_table[bin_count-1])) + it.weight;
                    if (sum > 64'hFFFFFF) sum = 64'hFFFFFF;
                    cdf_table[bin_count] = sum[23:0];
                    bin_count++;
                end
            end
            pccs_pkg::OP_SAMPLE: begin
                if (bin_count == 0 || cdf_table[bin_count-1] == 0) begin
                    r.status = pccs_pkg::ST_EMPTY;
                end else begin
                    total = 64'(cdf_table[bin_count-1]);
                    scaled = 64'(it.sample_u) * total;
                    k = 0;
                    for (int i = 0; i < bin_count; i++)
                        if ((64'(cdf_table[i]) << 16) <= scaled) k = i + 1;
                    if (k >= bin_count) k = bin_count - 1;
                    lower = (k == 0) ? 64'd0 : 64'(cdf_table[k-1]);
                    upper = 64'(cdf_table[k]);
                    num = scaled - (lower << 16);
                    r.bin_index = 8'(k);
                    r.remapped_u = (upper > lower) ? 16'(num / (upper - lower)) : 16'd0;
                end
            end
            pccs_pkg::OP_CLEAR: bin_count = 0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch %s got %0d want %0d", what, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && in_stall)) begin
            if (pending_q.size() > 0 && !hold_sender && $urandom_range(99) >= quiet_pct) begin
                in_data <= pending_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= i_rst_n ? ($urandom_range(99) < quiet_pct) : 1'b0;
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !in_stall) expected_q = {expected_q, predict_draw(in_data)};
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report("unexpected transfer", 32'd0, 32'd0);
                end else begin
                    if (out_data.bin_index != expected_q[0].bin_index)
                        report("bin_index", 32'(out_data.bin_index),
                               32'(expected_q[0].bin_index));
                    if (out_data.remapped_u != expected_q[0].remapped_u)
                        report("remapped_u", 32'(out_data.remapped_u),
                               32'(expected_q[0].remapped_u));
                    if (out_data.status != expected_q[0].status)
                        report("status", 32'(out_data.status), 32'(expected_q[0].status));
                    void'(expected_q.pop_front());
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    function automatic pccs_pkg::t_in_item mk(logic [1:0] op, logic [15:0] w,
                                              logic [15:0] u);
        pccs_pkg::t_in_item it;
        it.operation = op;
        it.weight = w;
        it.sample_u = u;
        return it;
    endfunction

    task automatic add_item(pccs_pkg::t_in_item it);
        pending_q = {pending_q, it};
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        int n, r;
        bin_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        add_item(mk(pccs_pkg::OP_SAMPLE, 16'hFFFF, 16'h1234));
        add_item(mk(pccs_pkg::OP_NOP, 16'hFFFF, 16'hFFFF));
        add_item(mk(pccs_pkg::OP_APPEND, 16'd0, 16'hFFFF));
        add_item(mk(pccs_pkg::OP_SAMPLE, 16'd0, 16'h8000));
        add_item(mk(pccs_pkg::OP_APPEND, 16'hFFFF, 16'd0));
        add_item(mk(pccs_pkg::OP_APPEND, 16'd1, 16'd0));
        add_item(mk(pccs_pkg::OP_APPEND, 16'd0, 16'd0));
        add_item(mk(pccs_pkg::OP_APPEND, 16'h5555, 16'd0));
        add_item(mk(pccs_pkg::OP_SAMPLE, 16'h0, 16'd0));
        add_item(mk(pccs_pkg::OP_SAMPLE, 16'h0, 16'hFFFF));
        add_item(mk(pccs_pkg::OP_SAMPLE, 16'hAAAA, 16'hAAAA));
        add_item(mk(pccs_pkg::OP_SAMPLE, 16'h5555, 16'h5555));
        add_item(mk(pccs_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF));
        add_item(mk(pccs_pkg::OP_SAMPLE, 16'd0, 16'h4000));
        // fill to full with big weights, then overflow
        for (int i = 0; i < ENTRIES + 2; i++)
            add_item(mk(pccs_pkg::OP_APPEND, 16'hFFFF - 16'(i), 16'(i)));
        add_item(mk(pccs_pkg::OP_SAMPLE, 16'd0, 16'hFFFF));
        add_item(mk(pccs_pkg::OP_SAMPLE, 16'd0, 16'd1));
        add_item(mk(pccs_pkg::OP_CLEAR, 16'd0, 16'd0));
        // sender holds off until everything has come back
        drain();
        hold_sender = 1'b1;
        repeat (30) @(posedge i_clk);
        hold_sender = 1'b0;
        // random: build small tables and sample them
        n = 0;
        while (n < 125) begin
            if (n > 30 && n < 100) quiet_pct = 0;
            else quiet_pct = 27;
            r = $urandom_range(99);
            if (r < 4) add_item(mk(pccs_pkg::OP_CLEAR, 16'($urandom), 16'($urandom)));
            else if (r < 6) add_item(mk(pccs_pkg::OP_NOP, 16'($urandom), 16'($urandom)));
            else if (r < 40)
                add_item(mk(pccs_pkg::OP_APPEND,
                    ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom), 16'($urandom)));
            else
                add_item(mk(pccs_pkg::OP_SAMPLE, 16'($urandom), 16'($urandom)));
            n++;
            if (pending_q.size() > 8) @(posedge i_clk);
            while (pending_q.size() > 8) @(posedge i_clk);
        end
        drain();
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

`default_nettype wire
